/* rtl/ascon_pkg.sv */
// Shared constants and types for the Ascon permutation round engine.
// Holds the state geometry, digit size, round limits and the linear-layer
// rotation amounts; no dependencies.
package ascon_pkg;

   // state geometry
   localparam int WORD_W    = 64;
   localparam int NUM_WORDS = 5;
   localparam int STATE_W   = WORD_W * NUM_WORDS;

   // column digit processed per cycle by the serial datapath
   localparam int DIGIT       = 8;
   localparam int DIGITS      = WORD_W / DIGIT;
   localparam int DIGIT_CNT_W = $clog2(DIGITS);

   // round indexing
   localparam int              ROUND_W    = 4;
   localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd11;

   // round constant width (low byte of x2)
   localparam int RC_W = 2 * ROUND_W;

   // linear layer rotation pairs for x0..x4
   localparam int ROT_A [NUM_WORDS] = '{19, 61, 1, 10, 7};
   localparam int ROT_B [NUM_WORDS] = '{28, 39, 6, 17, 41};

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [DIGIT-1:0]  digit_type;

   // round constant ((15 - r) << 4) | r
   function automatic logic [RC_W-1:0] round_const(input logic [ROUND_W-1:0] r);
      round_const = {~r, r};
   endfunction

endpackage

/* rtl/ascon_permutation_rounds.sv */
// Ascon permutation engine, column-serial datapath over a 320-bit state.
// Depends on ascon_pkg for geometry, digit size, round limits and rotations.
//
// Load five 64-bit words on req_tdata and the first round index on req_tuser;
// rounds run from that index through round 11 (0 gives p12, 4 gives p8, 6
// gives p6, an index above 11 returns the words unchanged). Each round is
// one pass of the S-box over the state columns, DIGIT columns per cycle,
// then one pass of the linear layer over a rotating copy, DIGIT bits per
// cycle. One item is worked on at a time; the next one is taken as soon as
// the finished state has moved into the output register.
module ascon_permutation_rounds (
   input  logic                           clock,
   input  logic                           reset,
   // request: tdata = word_in_0, word_in_1, word_in_2, word_in_3, word_in_4
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ascon_pkg::STATE_W-1:0]  req_tdata,
   // request: tuser = first_round
   input  logic [ascon_pkg::ROUND_W-1:0]  req_tuser,
   // response: tdata = word_out_0, word_out_1, word_out_2, word_out_3, word_out_4
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ascon_pkg::STATE_W-1:0]  rsp_tdata
);

   localparam int W = ascon_pkg::WORD_W;
   localparam int N = ascon_pkg::NUM_WORDS;
   localparam int D = ascon_pkg::DIGIT;
   localparam logic [ascon_pkg::DIGIT_CNT_W-1:0] LAST_DIGIT =
      ascon_pkg::DIGIT_CNT_W'(ascon_pkg::DIGITS - 1);

   // sequencer states
   localparam int                ST_W    = 2;
   localparam logic [ST_W-1:0]   ST_IDLE = 2'd0;
   localparam logic [ST_W-1:0]   ST_SBOX = 2'd1;
   localparam logic [ST_W-1:0]   ST_LIN  = 2'd2;
   localparam logic [ST_W-1:0]   ST_HOLD = 2'd3;

   logic [ST_W-1:0]                      state_ff, state_in;
   logic [ascon_pkg::DIGIT_CNT_W-1:0]    digit_ff, digit_in;
   logic [ascon_pkg::ROUND_W-1:0]        round_ff, round_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   ascon_pkg::word_type                  s_ff [N];
   ascon_pkg::word_type                  s_in [N];
   ascon_pkg::word_type                  c_ff [N];
   ascon_pkg::word_type                  c_in [N];
   logic [ascon_pkg::STATE_W-1:0]        out_ff, out_in;
   logic                                 out_load;

   ascon_pkg::digit_type                 rc_digit;
   ascon_pkg::digit_type                 a_dig [N];
   ascon_pkg::digit_type                 t_dig [N];
   ascon_pkg::digit_type                 x_dig [N];
   ascon_pkg::digit_type                 sb_dig [N];
   ascon_pkg::digit_type                 lin_dig [N];
   ascon_pkg::word_type                  rc_word;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_ff;

   // round constant digit for the current column group
   assign rc_word  = W'(ascon_pkg::round_const(round_ff));
   assign rc_digit = D'(rc_word >> (digit_ff * D));

   // bitsliced S-box on the low digit of each state word
   always_comb begin
      for (int k = 0; k < N; k++) begin
         a_dig[k] = s_ff[k][D-1:0];
      end
      t_dig[0] = a_dig[0] ^ a_dig[4];
      t_dig[1] = a_dig[1];
      t_dig[2] = a_dig[2] ^ a_dig[1] ^ rc_digit;
      t_dig[3] = a_dig[3];
      t_dig[4] = a_dig[4] ^ a_dig[3];
      for (int k = 0; k < N; k++) begin
         x_dig[k] = t_dig[k] ^ (~t_dig[(k + 1) % N] & t_dig[(k + 2) % N]);
      end
      sb_dig[0] = x_dig[0] ^ x_dig[4];
      sb_dig[1] = x_dig[1] ^ x_dig[0];
      sb_dig[2] = ~x_dig[2];
      sb_dig[3] = x_dig[3] ^ x_dig[2];
      sb_dig[4] = x_dig[4];
   end

   // linear layer taps on the rotating S-box output
   for (genvar k = 0; k < N; k++) begin : g_lin
      for (genvar j = 0; j < D; j++) begin : g_bit
         assign lin_dig[k][j] = c_ff[k][j]
                              ^ c_ff[k][(j + ascon_pkg::ROT_A[k]) % W]
                              ^ c_ff[k][(j + ascon_pkg::ROT_B[k]) % W];
      end
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      digit_in     = digit_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      out_load     = 1'b0;
      for (int k = 0; k < N; k++) begin
         s_in[k] = s_ff[k];
         c_in[k] = c_ff[k];
      end

      // drop the result once the transaction completes
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int k = 0; k < N; k++) begin
                  s_in[k] = req_tdata[k*W +: W];
               end
               round_in = req_tuser;
               digit_in = '0;
               state_in = (req_tuser > ascon_pkg::LAST_ROUND) ? ST_HOLD : ST_SBOX;
            end
         end
         ST_SBOX: begin
            // shift state out low digit first, collect S-box output at the top
            for (int k = 0; k < N; k++) begin
               s_in[k] = s_ff[k] >> D;
               c_in[k] = {sb_dig[k], c_ff[k][W-1:D]};
            end
            digit_in = digit_ff + 1'b1;
            if (digit_ff == LAST_DIGIT) begin
               digit_in = '0;
               state_in = ST_LIN;
            end
         end
         ST_LIN: begin
            // rotate S-box output, rebuild the state from the taps
            for (int k = 0; k < N; k++) begin
               c_in[k] = {c_ff[k][D-1:0], c_ff[k][W-1:D]};
               s_in[k] = {lin_dig[k], s_ff[k][W-1:D]};
            end
            digit_in = digit_ff + 1'b1;
            if (digit_ff == LAST_DIGIT) begin
               digit_in = '0;
               round_in = round_ff + ascon_pkg::ROUND_W'(1);
               state_in = (round_ff == ascon_pkg::LAST_ROUND) ? ST_HOLD : ST_SBOX;
            end
         end
         ST_HOLD: begin
            // hand the finished state to the output register when it is free
            if (!rsp_valid_ff || rsp_tready) begin
               for (int k = 0; k < N; k++) begin
                  out_in[k*W +: W] = s_ff[k];
               end
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         digit_ff     <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         digit_ff     <= digit_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         s_ff[k] <= s_in[k];
         c_ff[k] <= c_in[k];
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

`ifndef SYNTHESIS
   // an index past the last round skips straight to the hand-off
   a_skip_rounds: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser > ascon_pkg::LAST_ROUND))
      |=> (state_ff == ST_HOLD))
      else $error("round index past the last round did not skip the rounds");

   // the S-box and linear passes never run on a round beyond the last
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SBOX) || (state_ff == ST_LIN)) |-> (round_ff <= ascon_pkg::LAST_ROUND))
      else $error("round counter ran past the last round");

   // the last linear pass of the last round ends the permutation
   a_finish: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_LIN) && (digit_ff == LAST_DIGIT) &&
       (round_ff == ascon_pkg::LAST_ROUND)) |=> (state_ff == ST_HOLD))
      else $error("permutation did not finish after the last round");

   // a new result only appears out of the hand-off state
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_HOLD))
      else $error("result raised outside the hand-off state");

   // every S-box pass starts on the first column digit
   a_pass_start: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SBOX) && ($past(state_ff) != ST_SBOX)) |-> (digit_ff == '0))
      else $error("S-box pass started off the first digit");
`endif

endmodule

/* dv/tb_ascon_permutation_rounds.sv */
// Self-checking testbench for ascon_permutation_rounds: random and directed
// permutation requests, with results checked against an in-bench round model.
// Depends on ascon_pkg and the ascon_permutation_rounds RTL.
module tb_ascon_permutation_rounds;
   timeunit 1ns;
   timeprecision 1ps;

   // receiver ready patterns
   typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_type;

   localparam int MAX_REPORTS  = 10;
   localparam int HOLD_CYCLES  = 800;
   localparam int TAIL_CYCLES  = 250;
   localparam int RANDOM_ITEMS = 1330;

   // Predict permuted states and check each response transaction in order.
   class perm_scoreboard_type;
      logic [ascon_pkg::STATE_W-1:0] expected_states [$];
      int mismatches;
      int reports;

      function new();
         mismatches = 0;
         reports    = 0;
      endfunction

      // rotate right by 1..63
      function ascon_pkg::word_type ror(ascon_pkg::word_type x, int n);
         return (x >> n) | (x << (ascon_pkg::WORD_W - n));
      endfunction

      function logic [ascon_pkg::STATE_W-1:0] ascon_rounds(
            logic [ascon_pkg::ROUND_W-1:0] first,
            logic [ascon_pkg::STATE_W-1:0] words);
         ascon_pkg::word_type s [ascon_pkg::NUM_WORDS];
         ascon_pkg::word_type c [ascon_pkg::NUM_WORDS];
         logic [ascon_pkg::ROUND_W-1:0] r;
         logic [ascon_pkg::STATE_W-1:0] result;
         for (int i = 0; i < ascon_pkg::NUM_WORDS; i++) begin
            s[i] = words[i*ascon_pkg::WORD_W +: ascon_pkg::WORD_W];
         end
         // a start index past the last round leaves the words untouched
         r = first;
         while (r <= ascon_pkg::LAST_ROUND) begin
            s[2] = s[2] ^ {56'd0, (4'd15 - r), r};
            // substitution layer, bitsliced over all columns
            s[0] = s[0] ^ s[4];
            s[4] = s[4] ^ s[3];
            s[2] = s[2] ^ s[1];
            for (int i = 0; i < ascon_pkg::NUM_WORDS; i++) begin
               c[i] = s[i] ^ (~s[(i+1) % ascon_pkg::NUM_WORDS]
                              & s[(i+2) % ascon_pkg::NUM_WORDS]);
            end
            c[1] = c[1] ^ c[0];
            c[0] = c[0] ^ c[4];
            c[3] = c[3] ^ c[2];
            c[2] = ~c[2];
            // linear diffusion layer
            for (int i = 0; i < ascon_pkg::NUM_WORDS; i++) begin
               s[i] = c[i] ^ ror(c[i], ascon_pkg::ROT_A[i]) ^ ror(c[i], ascon_pkg::ROT_B[i]);
            end
            r = r + 1'b1;
         end
         for (int i = 0; i < ascon_pkg::NUM_WORDS; i++) begin
            result[i*ascon_pkg::WORD_W +: ascon_pkg::WORD_W] = s[i];
         end
         return result;
      endfunction

      function void note_input(logic [ascon_pkg::ROUND_W-1:0] first,
                               logic [ascon_pkg::STATE_W-1:0] words);
         expected_states.insert(expected_states.size(), ascon_rounds(first, words));
      endfunction

      function void check_result(logic [ascon_pkg::STATE_W-1:0] got);
         logic [ascon_pkg::STATE_W-1:0] want;
         if (expected_states.size() == 0) begin
            mismatches++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("response with no request pending: %h", got);
            end
            return;
         end
         want = expected_states.pop_front();
         if (got !== want) begin
            mismatches++;
            if (reports < MAX_REPORTS) begin
               reports++;
               for (int i = 0; i < ascon_pkg::NUM_WORDS; i++) begin
                  if (got[i*ascon_pkg::WORD_W +: ascon_pkg::WORD_W] !==
                      want[i*ascon_pkg::WORD_W +: ascon_pkg::WORD_W])
                     $display("word_out_%0d mismatch: expected %h, got %h", i,
                              want[i*ascon_pkg::WORD_W +: ascon_pkg::WORD_W],
                              got[i*ascon_pkg::WORD_W +: ascon_pkg::WORD_W]);
               end
            end
         end
      endfunction

      function int pending();
         return expected_states.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [ascon_pkg::STATE_W-1:0]   req_tdata;
   logic [ascon_pkg::ROUND_W-1:0]   req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [ascon_pkg::STATE_W-1:0]   rsp_tdata;

   perm_scoreboard_type perm_check = new();
   int hold_requests = 0;
   int burst_left = 0;

   ascon_permutation_rounds u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Record every accepted transaction on both channels.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            perm_check.note_input(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            perm_check.check_result(rsp_tdata);
      end
   end

   function automatic ascon_pkg::word_type rand_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [ascon_pkg::STATE_W-1:0] rand_state();
      logic [ascon_pkg::STATE_W-1:0] st;
      for (int i = 0; i < ascon_pkg::NUM_WORDS; i++) begin
         st[i*ascon_pkg::WORD_W +: ascon_pkg::WORD_W] = rand_word();
      end
      return st;
   endfunction

   // Offer one request, wait for acceptance, then idle per the burst pattern.
   task automatic send_state(input logic [ascon_pkg::ROUND_W-1:0] first,
                             input logic [ascon_pkg::STATE_W-1:0] words);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= words;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= rand_state();
            req_tuser  <= 4'($urandom_range(0, 15));
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and wait for every pending response.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (perm_check.pending() != 0);
   endtask

   // Receiver: drive ready on changing patterns, plus long holds on request.
   initial begin
      rx_mode_type mode;
      int mode_left;
      int hold_served;
      rsp_tready  = 1'b0;
      mode        = RX_ALWAYS;
      mode_left   = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               RX_ALWAYS: rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               RX_BLOCKS: rsp_tready <= mode_left[4];
            endcase
         end
      end
   end

   // Stimulus and final verdict.
   initial begin
      logic [ascon_pkg::STATE_W-1:0] st;
      logic [ascon_pkg::ROUND_W-1:0] first;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // every start index, including the ones past the last round
      for (int k = 0; k < 16; k++) begin
         case (k % 4)
            0:       st = '0;
            1:       st = '1;
            2:       st = {ascon_pkg::NUM_WORDS{64'h5555_5555_5555_5555}};
            default: st = rand_state();
         endcase
         send_state(k[ascon_pkg::ROUND_W-1:0], st);
      end
      // single first-state bit in each word through the full permutation
      for (int w = 0; w < ascon_pkg::NUM_WORDS; w++) begin
         st = '0;
         st[w*ascon_pkg::WORD_W + ascon_pkg::WORD_W - 1] = 1'b1;
         send_state(4'd0, st);
      end
      send_state(4'd0, {ascon_pkg::NUM_WORDS{64'hAAAA_AAAA_AAAA_AAAA}});
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // hold the receiver off while requests keep coming
         if (n == 300 || n == 1000)
            hold_requests <= hold_requests + 1;
         if (n == 650)
            drain();
         if ($urandom_range(0, 19) < 3)
            first = 4'($urandom_range(12, 15));
         else
            first = 4'($urandom_range(0, 11));
         send_state(first, rand_state());
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (perm_check.mismatches == 0 && perm_check.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Bound the run.
   initial begin
      #15_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/ascon_pkg.sv
rtl/ascon_permutation_rounds.sv
dv/tb_ascon_permutation_rounds.sv
